FILE: hdl/rqs_pkg.sv
// Ready-queue scheduler package: queue entry and result record types,
// policy, result and config index codes, defaults, sequencer states. No dependencies.
package rqs_pkg;

  localparam int unsigned QueueDepthDef = 16;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_SRTF = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  localparam logic [1:0] KIND_DONE     = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_ZERO_BST = 2'd2;

  localparam logic [0:0] CFG_POLICY  = 1'b0;
  localparam logic [0:0] CFG_QUANTUM = 1'b1;

  localparam logic [7:0] QuantumRst = 8'd4;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] arrival;
    logic [11:0] burst;
    logic [11:0] remaining;
    logic [15:0] start;
    logic        started;
    logic [15:0] wait_cnt;
  } slot_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [11:0] burst;
    logic [15:0] start;
    logic [15:0] fin;
    logic [15:0] wait_cnt;
    logic [1:0]  kind;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_WR,
    ST_HEAD_UPD,
    ST_WT_RD,
    ST_WT_WR,
    ST_FINISH
  } state_e;

endpackage

FILE: hdl/rqs_seq.sv
// Ready-queue sequencer: circular queue memory plus the FSM that walks it
// for sorted insertion, wait-count sweep and head retire/rotate.
// Depends on rqs_pkg.
module rqs_seq #(
  parameter int unsigned QUEUE_DEPTH = rqs_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              mode_i,
  input  logic [7:0]        new_id_i,
  input  logic [11:0]       new_burst_i,
  input  logic [1:0]        policy_i,
  input  logic [7:0]        quantum_i,
  output logic              busy_o,
  output rqs_pkg::rec_t     rec_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  rqs_pkg::slot_t mem [QUEUE_DEPTH];
  rqs_pkg::slot_t rdata_q;
  logic           we;
  logic [IW-1:0]  waddr, raddr;
  rqs_pkg::slot_t wdata;

  rqs_pkg::state_e state_q, state_d;
  logic [IW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [15:0]     time_q, time_d;
  logic [7:0]      slice_q, slice_d;
  rqs_pkg::slot_t  item_q, item_d;
  rqs_pkg::slot_t  hslot_q, hslot_d;

  // logical offset from head -> physical slot
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW+1-IW){1'b0}}, hd} + {1'b0, off};
    if (sum >= {1'b0, DepthC}) sum = sum - {1'b0, DepthC};
    return sum[IW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rqs_pkg::ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      time_q  <= '0;
      slice_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      time_q  <= time_d;
      slice_q <= slice_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    item_q  <= item_d;
    hslot_q <= hslot_d;
  end

  logic [CW-1:0] limit;
  logic [11:0]   key;
  logic [7:0]    slice_inc;
  logic [CW-1:0] pos_m1;

  assign limit     = (policy_i == rqs_pkg::POL_SJF) ? CW'(1) : '0;
  assign key       = (policy_i == rqs_pkg::POL_SJF) ? rdata_q.burst : rdata_q.remaining;
  assign slice_inc = slice_q + 8'd1;
  assign pos_m1    = pos_q - CW'(1);
  assign busy_o    = (state_q != rqs_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    time_d  = time_q;
    slice_d = slice_q;
    item_d  = item_q;
    hslot_d = hslot_q;
    we      = 1'b0;
    waddr   = head_q;
    wdata   = item_q;
    raddr   = head_q;
    rec_o   = '0;

    case (state_q)
      rqs_pkg::ST_IDLE: begin
        if (start_i) begin
          if (mode_i) begin
            if (count_q == '0) begin
              time_d  = time_q + 16'd1;
              slice_d = '0;
            end else begin
              raddr   = head_q;
              state_d = rqs_pkg::ST_HEAD_UPD;
            end
          end else if (new_burst_i == '0 || count_q == DepthC) begin
            rec_o.valid   = 1'b1;
            rec_o.id      = new_id_i;
            rec_o.arrival = time_q;
            rec_o.burst   = new_burst_i;
            rec_o.kind    = (new_burst_i == '0) ? rqs_pkg::KIND_ZERO_BST
                                                : rqs_pkg::KIND_FULL;
          end else begin
            item_d = '{task_id: new_id_i, arrival: time_q, burst: new_burst_i,
                       remaining: new_burst_i, start: '0, started: 1'b0,
                       wait_cnt: '0};
            pos_d  = count_q;
            if ((policy_i == rqs_pkg::POL_SJF || policy_i == rqs_pkg::POL_SRTF)
                && count_q > limit) begin
              state_d = rqs_pkg::ST_INS_RD;
            end else begin
              state_d = rqs_pkg::ST_INS_WR;
            end
          end
        end
      end
      rqs_pkg::ST_INS_RD: begin
        raddr   = phys(head_q, pos_m1);
        state_d = rqs_pkg::ST_INS_CMP;
      end
      rqs_pkg::ST_INS_CMP: begin
        if (item_q.burst < key) begin
          // shift the larger key one place back
          we      = 1'b1;
          waddr   = phys(head_q, pos_q);
          wdata   = rdata_q;
          pos_d   = pos_m1;
          state_d = (pos_m1 > limit) ? rqs_pkg::ST_INS_RD : rqs_pkg::ST_INS_WR;
        end else begin
          state_d = rqs_pkg::ST_INS_WR;
        end
      end
      rqs_pkg::ST_INS_WR: begin
        we      = 1'b1;
        waddr   = phys(head_q, pos_q);
        wdata   = item_q;
        count_d = count_q + CW'(1);
        state_d = rqs_pkg::ST_IDLE;
      end
      rqs_pkg::ST_HEAD_UPD: begin
        hslot_d = rdata_q;
        if (!rdata_q.started) begin
          hslot_d.start   = time_q;
          hslot_d.started = 1'b1;
        end
        hslot_d.remaining = rdata_q.remaining - 12'd1;
        pos_d   = CW'(1);
        state_d = (count_q > CW'(1)) ? rqs_pkg::ST_WT_RD : rqs_pkg::ST_FINISH;
      end
      rqs_pkg::ST_WT_RD: begin
        raddr   = phys(head_q, pos_q);
        state_d = rqs_pkg::ST_WT_WR;
      end
      rqs_pkg::ST_WT_WR: begin
        we    = 1'b1;
        waddr = phys(head_q, pos_q);
        wdata = rdata_q;
        if (rdata_q.wait_cnt != 16'hFFFF) wdata.wait_cnt = rdata_q.wait_cnt + 16'd1;
        pos_d   = pos_q + CW'(1);
        state_d = ((pos_q + CW'(1)) < count_q) ? rqs_pkg::ST_WT_RD : rqs_pkg::ST_FINISH;
      end
      rqs_pkg::ST_FINISH: begin
        time_d  = time_q + 16'd1;
        state_d = rqs_pkg::ST_IDLE;
        if (hslot_q.remaining == '0) begin
          rec_o.valid    = 1'b1;
          rec_o.id       = hslot_q.task_id;
          rec_o.arrival  = hslot_q.arrival;
          rec_o.burst    = hslot_q.burst;
          rec_o.start    = hslot_q.start;
          rec_o.fin      = time_q + 16'd1;
          rec_o.wait_cnt = hslot_q.wait_cnt;
          rec_o.kind     = rqs_pkg::KIND_DONE;
          head_d  = phys(head_q, CW'(1));
          count_d = count_q - CW'(1);
          slice_d = '0;
        end else if (policy_i == rqs_pkg::POL_RR && slice_inc >= quantum_i) begin
          // rotate head to tail
          we      = 1'b1;
          waddr   = phys(head_q, count_q);
          wdata   = hslot_q;
          head_d  = phys(head_q, CW'(1));
          slice_d = '0;
        end else begin
          we      = 1'b1;
          waddr   = head_q;
          wdata   = hslot_q;
          slice_d = (policy_i == rqs_pkg::POL_RR) ? slice_inc : '0;
        end
      end
      default: state_d = rqs_pkg::ST_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("queue count above depth");

  a_rec_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_o.valid |-> (state_q == rqs_pkg::ST_IDLE || state_q == rqs_pkg::ST_FINISH))
    else $error("result outside idle/finish");

  a_finish_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rqs_pkg::ST_FINISH |-> count_q != '0)
    else $error("retire on empty queue");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rqs_pkg::ST_INS_WR |-> count_q < DepthC)
    else $error("insert into full queue");

endmodule

FILE: hdl/ready_queue_scheduler.sv
// Ready-queue scheduler (FCFS, SJF, SRTF, round robin): a transaction is taken
// when start_i is high and busy_o low. A rejected arrival is answered from the
// idle state; an appended one is written after a read/compare pass over each queue
// entry whose key is compared under SJF/SRTF; a tick on an empty queue only
// advances time, else it updates the head and walks the queue memory one entry
// per read/write pair. Each result is shown for one cycle with result_valid_o,
// in the cycle after the transaction ends; the receiver cannot stall it.
// Depends on rqs_pkg, rqs_seq.
module ready_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = rqs_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [7:0]  new_id_i,
  input  logic [11:0] new_burst_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic [7:0]  done_id_o,
  output logic [15:0] done_arrival_o,
  output logic [11:0] done_burst_o,
  output logic [15:0] done_start_o,
  output logic [15:0] done_end_o,
  output logic [15:0] done_wait_o,
  output logic [1:0]  result_kind_o
);

  logic [1:0]    policy_q;
  logic [7:0]    quantum_q;
  logic          rec_vld_q;
  rqs_pkg::rec_t rec, rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= rqs_pkg::POL_FCFS;
      quantum_q <= rqs_pkg::QuantumRst;
      rec_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == rqs_pkg::CFG_POLICY)  policy_q  <= cfg_wdata_i[1:0];
      if (cfg_we_i && cfg_idx_i == rqs_pkg::CFG_QUANTUM) quantum_q <= cfg_wdata_i;
      rec_vld_q <= rec.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec.valid) begin
      rec_q <= rec;
    end
  end

  rqs_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .mode_i      (mode_i),
    .new_id_i    (new_id_i),
    .new_burst_i (new_burst_i),
    .policy_i    (policy_q),
    .quantum_i   (quantum_q),
    .busy_o      (busy_o),
    .rec_o       (rec)
  );

  assign result_valid_o = rec_vld_q;
  assign done_id_o      = rec_q.id;
  assign done_arrival_o = rec_q.arrival;
  assign done_burst_o   = rec_q.burst;
  assign done_start_o   = rec_q.start;
  assign done_end_o     = rec_q.fin;
  assign done_wait_o    = rec_q.wait_cnt;
  assign result_kind_o  = rec_q.kind;

endmodule

FILE: sim/ready_queue_scheduler_chk.sv
// Checker for the ready-queue scheduler: predicts finished and rejected task
// records from accepted transactions and config writes, and compares them.
// Depends on rqs_pkg.
`timescale 1ns / 100ps

module ready_queue_scheduler_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        mode_i,
  input  logic [7:0]  new_id_i,
  input  logic [11:0] new_burst_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        result_valid_i,
  input  logic [7:0]  done_id_i,
  input  logic [15:0] done_arrival_i,
  input  logic [11:0] done_burst_i,
  input  logic [15:0] done_start_i,
  input  logic [15:0] done_end_i,
  input  logic [15:0] done_wait_i,
  input  logic [1:0]  result_kind_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          record_cnt_o
);

  localparam int Depth = rqs_pkg::QueueDepthDef;

  typedef struct {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [11:0] burst;
    logic [15:0] start;
    logic [15:0] fin;
    logic [15:0] wait_cnt;
    logic [1:0]  kind;
  } task_rec_t;

  rqs_pkg::slot_t ready_q [Depth];
  int             occupancy;
  logic [15:0]    now;
  logic [7:0]     slice;
  logic [1:0]     sched_pol;
  logic [7:0]     slice_len;
  task_rec_t      records_due [$];

  function automatic task_rec_t mk_rec(logic [7:0] id, logic [15:0] arr, logic [11:0] bst,
                                       logic [15:0] st, logic [15:0] fin, logic [15:0] wt,
                                       logic [1:0] kind);
    task_rec_t r;
    r.id = id; r.arrival = arr; r.burst = bst; r.start = st;
    r.fin = fin; r.wait_cnt = wt; r.kind = kind;
    return r;
  endfunction

  task automatic enqueue_task(logic [7:0] id, logic [11:0] bst);
    int pos;
    rqs_pkg::slot_t s;
    if (bst == '0) begin
      records_due.push_back(mk_rec(id, now, bst, '0, '0, '0, rqs_pkg::KIND_ZERO_BST));
      return;
    end
    if (occupancy >= Depth) begin
      records_due.push_back(mk_rec(id, now, bst, '0, '0, '0, rqs_pkg::KIND_FULL));
      return;
    end
    s = '{task_id: id, arrival: now, burst: bst, remaining: bst, start: '0,
          started: 1'b0, wait_cnt: '0};
    pos = occupancy;
    if (sched_pol == rqs_pkg::POL_SJF) begin
      while (pos > 1 && bst < ready_q[pos-1].burst) pos--;
    end else if (sched_pol == rqs_pkg::POL_SRTF) begin
      while (pos > 0 && bst < ready_q[pos-1].remaining) pos--;
    end
    for (int i = occupancy; i > pos; i--) ready_q[i] = ready_q[i-1];
    ready_q[pos] = s;
    occupancy++;
  endtask

  task automatic run_tick();
    rqs_pkg::slot_t h;
    if (occupancy == 0) begin
      now++;
      slice = '0;
      return;
    end
    if (!ready_q[0].started) begin
      ready_q[0].start = now;
      ready_q[0].started = 1'b1;
    end
    if (ready_q[0].remaining != 0) ready_q[0].remaining--;
    for (int i = 1; i < occupancy; i++)
      if (ready_q[i].wait_cnt != 16'hFFFF) ready_q[i].wait_cnt++;
    now++;
    h = ready_q[0];
    if (h.remaining == 0) begin
      records_due.push_back(mk_rec(h.task_id, h.arrival, h.burst, h.start, now,
                                   h.wait_cnt, rqs_pkg::KIND_DONE));
      for (int i = 0; i < occupancy - 1; i++) ready_q[i] = ready_q[i+1];
      occupancy--;
      slice = '0;
      return;
    end
    if (sched_pol == rqs_pkg::POL_RR) begin
      slice++;
      if (slice >= slice_len) begin
        for (int i = 0; i < occupancy - 1; i++) ready_q[i] = ready_q[i+1];
        ready_q[occupancy-1] = h;
        slice = '0;
      end
    end else begin
      slice = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    task_rec_t e;
    if (!rst_ni) begin
      occupancy = 0;
      now = '0;
      slice = '0;
      sched_pol = rqs_pkg::POL_FCFS;
      slice_len = rqs_pkg::QuantumRst;
      records_due.delete();
      fail_cnt_o = 0;
      record_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (result_valid_i) begin
        record_cnt_o++;
        if (records_due.size() == 0) begin
          $error("unexpected result: id %0d kind %0d", done_id_i, result_kind_i);
          fail_cnt_o++;
        end else begin
          e = records_due.pop_front();
          if (done_id_i !== e.id) begin
            $error("done_id: expected %0d, got %0d", e.id, done_id_i); fail_cnt_o++;
          end
          if (done_arrival_i !== e.arrival) begin
            $error("done_arrival: expected %0d, got %0d", e.arrival, done_arrival_i);
            fail_cnt_o++;
          end
          if (done_burst_i !== e.burst) begin
            $error("done_burst: expected %0d, got %0d", e.burst, done_burst_i);
            fail_cnt_o++;
          end
          if (done_start_i !== e.start) begin
            $error("done_start: expected %0d, got %0d", e.start, done_start_i);
            fail_cnt_o++;
          end
          if (done_end_i !== e.fin) begin
            $error("done_end: expected %0d, got %0d", e.fin, done_end_i); fail_cnt_o++;
          end
          if (done_wait_i !== e.wait_cnt) begin
            $error("done_wait: expected %0d, got %0d", e.wait_cnt, done_wait_i);
            fail_cnt_o++;
          end
          if (result_kind_i !== e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, result_kind_i);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == rqs_pkg::CFG_POLICY) sched_pol = cfg_wdata_i[1:0];
        else slice_len = cfg_wdata_i;
      end
      // a transaction is taken only while the block is not busy
      if (start_i && !busy_i) begin
        if (mode_i) run_tick();
        else enqueue_task(new_id_i, new_burst_i);
      end
      pending_o = records_due.size();
    end
  end

endmodule

FILE: sim/ready_queue_scheduler_tb.sv
// Testbench top for ready_queue_scheduler: clock, reset, directed and random
// arrivals/ticks across all policies, verdict. Depends on rqs_pkg and the checker.
`timescale 1ns / 100ps

module ready_queue_scheduler_tb;

  localparam logic ModeArrive = 1'b0;
  localparam logic ModeTick   = 1'b1;
  localparam int   SettleCyc  = 40;
  localparam longint CycLimit = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        mode_i = 1'b0;
  logic [7:0]  new_id_i = '0;
  logic [11:0] new_burst_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        busy_o, result_valid_o;
  logic [7:0]  done_id_o;
  logic [15:0] done_arrival_o, done_start_o, done_end_o, done_wait_o;
  logic [11:0] done_burst_o;
  logic [1:0]  result_kind_o;
  int          fail_cnt, pending, record_cnt;
  int          sent_cnt;
  longint      cyc;
  bit          gaps_on;

  ready_queue_scheduler u_top (.*);

  ready_queue_scheduler_chk u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .new_id_i, .new_burst_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .result_valid_i(result_valid_o), .done_id_i(done_id_o),
    .done_arrival_i(done_arrival_o), .done_burst_i(done_burst_o),
    .done_start_i(done_start_o), .done_end_i(done_end_o), .done_wait_i(done_wait_o),
    .result_kind_i(result_kind_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .record_cnt_o(record_cnt)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > CycLimit) begin
        $display("timeout after %0d cycles", cyc);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // leaves start_i high at a falling edge; the next call lowers it if needed
  task automatic issue(logic m, logic [7:0] id, logic [11:0] bst);
    @(negedge clk_i);
    while (busy_o || (gaps_on && $urandom_range(99) < 24)) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    mode_i = m;
    new_id_i = id;
    new_burst_i = bst;
    sent_cnt++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_phase(int n);
    logic [11:0] b;
    for (int k = 0; k < n; k++) begin
      gaps_on = (k % 200) > 60;
      if ($urandom_range(99) < 58) begin
        issue(ModeTick, 8'($urandom), 12'($urandom));
      end else begin
        case ($urandom_range(19))
          0:       b = '0;
          1:       b = 12'($urandom);
          2, 3:    b = 12'($urandom_range(64, 1));
          default: b = 12'($urandom_range(12, 1));
        endcase
        issue(ModeArrive, 8'($urandom), b);
      end
    end
    settle();
  endtask

  initial begin
    sent_cnt = 0;
    gaps_on = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero burst, full queue, extremes of the fields
    gaps_on = 1'b1;
    issue(ModeArrive, 8'hFF, 12'd0);
    for (int k = 0; k < 16; k++) issue(ModeArrive, 8'(k * 17), (k == 15) ? 12'hFFF : 12'd1);
    issue(ModeArrive, 8'hAA, 12'h555);
    repeat (15) issue(ModeTick, 8'hFF, 12'hFFF);
    settle();

    random_phase(160);
    write_reg(rqs_pkg::CFG_POLICY, {6'b0, rqs_pkg::POL_SJF});
    random_phase(170);
    write_reg(rqs_pkg::CFG_POLICY, {6'b0, rqs_pkg::POL_SRTF});
    random_phase(170);
    write_reg(rqs_pkg::CFG_POLICY, {6'b0, rqs_pkg::POL_RR});
    write_reg(rqs_pkg::CFG_QUANTUM, 8'd1);
    random_phase(170);
    write_reg(rqs_pkg::CFG_QUANTUM, 8'd255);
    random_phase(150);
    write_reg(rqs_pkg::CFG_QUANTUM, 8'd0);
    random_phase(150);
    write_reg(rqs_pkg::CFG_QUANTUM, 8'($urandom_range(8, 2)));
    random_phase(170);
    write_reg(rqs_pkg::CFG_POLICY, 8'($urandom_range(3)));
    write_reg(rqs_pkg::CFG_QUANTUM, 8'($urandom_range(255, 1)));
    random_phase(150);
    write_reg(rqs_pkg::CFG_POLICY, {6'b0, rqs_pkg::POL_FCFS});
    random_phase(100);

    $display("%0d transactions sent, %0d task records checked (all four policies,",
             sent_cnt, record_cnt);
    $display("quantum 0/1/255, queue full, zero burst)");
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: ready_queue_scheduler.f
hdl/rqs_pkg.sv
hdl/rqs_seq.sv
hdl/ready_queue_scheduler.sv
sim/ready_queue_scheduler_chk.sv
sim/ready_queue_scheduler_tb.sv
